// File: rtl/cone_box_to_ground_position_macros.svh
// assertion macros for the cone box to ground position block
// needs clk and rst in the scope of the module that uses them
`ifndef CONE_BOX_TO_GROUND_POSITION_MACROS_SVH
`define CONE_BOX_TO_GROUND_POSITION_MACROS_SVH

// same-cycle implication
`define CBGP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CBGP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/cbgp_pkg.sv
// shared types, constants and helpers for the cone box to ground position block
// no dependencies
`timescale 1ns / 1ps

package cbgp_pkg;

  localparam int IMG_DIM_W   = 13;
  localparam int SIZE_W      = 16;
  localparam int BIG_SIZE_W  = 17;
  localparam int CAM_W       = 10;
  localparam int COLOR_W     = 3;
  localparam int POS_W       = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int DIR_FRAC    = 16;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_FACTOR     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BIG_SIZE_FACTOR = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CAMERA_HEIGHT   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BIG_CONE_COLOR  = 3'd5;

  // reset values
  localparam logic [IMG_DIM_W-1:0]  RST_IMAGE_WIDTH     = 13'd640;
  localparam logic [IMG_DIM_W-1:0]  RST_IMAGE_HEIGHT    = 13'd480;
  localparam logic [SIZE_W-1:0]     RST_SIZE_FACTOR     = 16'd30000;
  localparam logic [BIG_SIZE_W-1:0] RST_BIG_SIZE_FACTOR = 17'd46590;
  localparam logic [CAM_W-1:0]      RST_CAMERA_HEIGHT   = 10'd70;
  localparam logic [COLOR_W-1:0]    RST_BIG_CONE_COLOR  = 3'd0;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               neg_x;
    logic               neg_y;
  } side_t;

  // apply sign to a magnitude and clamp to the signed output range
  function automatic logic [POS_W-1:0] sat_signed(input logic [POS_W-1:0] mag,
                                                  input logic ovf, input logic neg);
    logic [POS_W-1:0] lim_pos;
    logic [POS_W-1:0] lim_neg;
    lim_pos = {1'b0, {(POS_W-1){1'b1}}};
    lim_neg = {1'b1, {(POS_W-1){1'b0}}};
    if (neg) begin
      return (ovf || mag > lim_neg) ? lim_neg : -mag;
    end else begin
      return (ovf || mag[POS_W-1]) ? lim_pos : mag;
    end
  endfunction

endpackage

// File: rtl/cone_box_to_ground_position.sv
// top level of the cone box to ground position block
// depends on cbgp_pkg, cbgp_sqrt_pipe and the assertion macro header
`timescale 1ns / 1ps

// Cone box to ground position. Each input word is one detected cone box; each output word
// is its ground position in signed fixed point (FRAC_BITS fraction bits), saturated to 24
// bits, with the color passed through. The slant range is the size factor (the big-cone
// factor when the color matches the big-cone color register) divided by the box height, the
// ground range is the root of range squared minus camera height squared, and it is split
// along the line from the box anchor to the reference point. The block is a fixed pipeline
// that takes one word every clock, unless a stalled output freezes every stage. Its stages
// are stage A, the longer of the range lane (17 divider stages, square, subtract, 17 +
// FRAC_BITS root stages) and the direction lane (square, sum, max(17, PIXEL_BITS + 5) + 17
// root stages), numerator and overflow check stages, 24 per-bit divider stages scaling each
// component, and the output register. s_tready is high when the output register is empty or
// being drained. Configuration must be written only while idle; the block does not check it.

`include "cone_box_to_ground_position_macros.svh"

module cone_box_to_ground_position #(
  parameter int PIXEL_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input word
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // box_left, box_top, box_width, box_height, zero fill
  input  logic [((4*PIXEL_BITS+7)/8)*8-1:0]    s_tdata,
  // color code
  input  logic [cbgp_pkg::COLOR_W-1:0]         s_tuser,
  // output word
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // forward_pos, lateral_pos
  output logic [2*cbgp_pkg::POS_W-1:0]         m_tdata,
  // color_out
  output logic [cbgp_pkg::COLOR_W-1:0]         m_tuser,
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [cbgp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cbgp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import cbgp_pkg::*;

  localparam int P   = PIXEL_BITS;
  localparam int RW  = BIG_SIZE_W;                        // slant range width
  localparam int NW  = 2*RW;                              // range squared
  localparam int DW  = RW + FRAC_BITS;                    // ground range root
  localparam int AW  = (P + 5 > 17) ? P + 5 : 17;         // offset magnitude, tenths
  localparam int SW  = 2*AW + 2;                          // sum of squares, even
  localparam int HW  = SW/2 + DIR_FRAC;                   // hypotenuse root
  localparam int L1  = RW + 2 + DW;
  localparam int L2  = 2 + HW;
  localparam int LAT = (L1 > L2) ? L1 : L2;
  localparam int PD1 = LAT - L1;
  localparam int PD2 = LAT - L2;
  localparam int QW  = POS_W;                             // quotient bits
  localparam int MW  = DW + AW;                           // scaled numerator
  localparam int RMW = HW + QW;                           // divider remainder
  localparam int CW  = MW + HW + 8;                       // overflow compare
  localparam int TOT = LAT + 4 + QW;
  localparam logic [HW-1:0] DEN_ONE = HW'(1) << DIR_FRAC;

  // configuration registers
  logic [IMG_DIM_W-1:0]  image_width;
  logic [IMG_DIM_W-1:0]  image_height;
  logic [SIZE_W-1:0]     size_factor;
  logic [BIG_SIZE_W-1:0] big_size_factor;
  logic [CAM_W-1:0]      camera_height;
  logic [COLOR_W-1:0]    big_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= RST_IMAGE_WIDTH;
      image_height    <= RST_IMAGE_HEIGHT;
      size_factor     <= RST_SIZE_FACTOR;
      big_size_factor <= RST_BIG_SIZE_FACTOR;
      camera_height   <= RST_CAMERA_HEIGHT;
      big_color       <= RST_BIG_CONE_COLOR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:     image_width     <= cfg_data[IMG_DIM_W-1:0];
        REG_IMAGE_HEIGHT:    image_height    <= cfg_data[IMG_DIM_W-1:0];
        REG_SIZE_FACTOR:     size_factor     <= cfg_data[SIZE_W-1:0];
        REG_BIG_SIZE_FACTOR: big_size_factor <= cfg_data[BIG_SIZE_W-1:0];
        REG_CAMERA_HEIGHT:   camera_height   <= cfg_data[CAM_W-1:0];
        REG_BIG_CONE_COLOR:  big_color       <= cfg_data[COLOR_W-1:0];
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // pipeline advance: everything moves together unless the output word is stuck
  logic           en;
  logic [TOT-1:0] vld;

  assign en       = !vld[TOT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[TOT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOT-2:0], s_tvalid};
    end
  end

  // input fields
  logic [P-1:0] box_left, box_top, box_width, box_height;
  assign box_left   = s_tdata[P-1:0];
  assign box_top    = s_tdata[2*P-1:P];
  assign box_width  = s_tdata[3*P-1:2*P];
  assign box_height = s_tdata[4*P-1:3*P];

  // stage A: factor select, divisor fix-up, offsets from anchor to reference point
  logic [RW-1:0] f_sel;
  logic [P-1:0]  bh_fix;
  logic [AW-1:0] xp, xn, yp, yn;
  logic [AW:0]   dxs, dys;

  assign f_sel  = (s_tuser == big_color) ? big_size_factor : RW'(size_factor);
  assign bh_fix = (box_height == '0) ? P'(1) : box_height;
  assign xp     = AW'(image_width >> 1) * AW'(10);
  assign xn     = AW'(box_left) * AW'(10) + AW'(box_width) * AW'(5);
  assign yp     = AW'(image_height) * AW'(15);
  assign yn     = AW'(box_top) * AW'(10) + AW'(box_height) * AW'(7);
  assign dxs    = {1'b0, xp} - {1'b0, xn};
  assign dys    = {1'b0, yp} - {1'b0, yn};

  logic [RW-1:0] a_f;
  logic [P-1:0]  a_bh;
  side_t         sb   [TOT-1];   // color and signs, one entry per stage before the output register
  logic [AW-1:0] ax_d [LAT+1];   // offset magnitudes up to the join
  logic [AW-1:0] ay_d [LAT+1];

  always_ff @(posedge clk) begin
    if (en) begin
      a_f            <= f_sel;
      a_bh           <= bh_fix;
      sb[0].color    <= s_tuser;
      sb[0].neg_x    <= dxs[AW];
      sb[0].neg_y    <= dys[AW];
      ax_d[0]        <= dxs[AW] ? AW'(-dxs) : dxs[AW-1:0];
      ay_d[0]        <= dys[AW] ? AW'(-dys) : dys[AW-1:0];
      for (int s = 1; s < TOT-1; s++) begin
        sb[s] <= sb[s-1];
      end
      for (int s = 1; s <= LAT; s++) begin
        ax_d[s] <= ax_d[s-1];
        ay_d[s] <= ay_d[s-1];
      end
    end
  end

  // range lane: restoring divider, one quotient bit per stage
  logic [P-1:0]  dv_rem [RW];
  logic [RW-1:0] dv_q   [RW];
  logic [RW-1:0] dv_num [RW];
  logic [P-1:0]  dv_den [RW];

  for (genvar k = 0; k < RW; k++) begin : g_div
    logic [P-1:0]  rem_in;
    logic [RW-1:0] q_in;
    logic [RW-1:0] num_in;
    logic [P-1:0]  den_in;
    logic [P:0]    shifted;
    logic [P:0]    diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign q_in   = '0;
      assign num_in = a_f;
      assign den_in = a_bh;
    end else begin : g_rest
      assign rem_in = dv_rem[k-1];
      assign q_in   = dv_q[k-1];
      assign num_in = dv_num[k-1];
      assign den_in = dv_den[k-1];
    end

    assign shifted = {rem_in, num_in[RW-1-k]};
    assign diff    = shifted - {1'b0, den_in};
    assign ge      = shifted >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[k] <= ge ? diff[P-1:0] : shifted[P-1:0];
        dv_q[k]   <= {q_in[RW-2:0], ge};
        dv_num[k] <= num_in;
        dv_den[k] <= den_in;
      end
    end
  end

  // range squared, then less camera height squared, clamped at zero
  logic [NW-1:0]        r2;
  logic [NW-1:0]        rad_d;
  logic [2*CAM_W-1:0]   h2;
  logic [DW-1:0]        d_root;

  assign h2 = camera_height * camera_height;

  always_ff @(posedge clk) begin
    if (en) begin
      r2    <= NW'(dv_q[RW-1]) * NW'(dv_q[RW-1]);
      rad_d <= (r2 > NW'(h2)) ? r2 - NW'(h2) : '0;
    end
  end

  cbgp_sqrt_pipe #(.RTW(DW)) u_range_root (
    .clk      (clk),
    .en       (en),
    .radicand ({rad_d, {(2*FRAC_BITS){1'b0}}}),
    .root     (d_root)
  );

  // direction lane: squared offsets, sum, root with 16 fraction bits
  logic [2*AW-1:0] sqx, sqy;
  logic [SW-1:0]   hsum;
  logic [HW-1:0]   hyp_root;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx  <= (2*AW)'(ax_d[0]) * (2*AW)'(ax_d[0]);
      sqy  <= (2*AW)'(ay_d[0]) * (2*AW)'(ay_d[0]);
      hsum <= SW'(sqx) + SW'(sqy);
    end
  end

  cbgp_sqrt_pipe #(.RTW(HW)) u_hyp_root (
    .clk      (clk),
    .en       (en),
    .radicand ({hsum, {(2*DIR_FRAC){1'b0}}}),
    .root     (hyp_root)
  );

  // line up the two lanes
  logic [DW-1:0] d_j;
  logic [HW-1:0] hyp_j;

  if (PD1 == 0) begin : g_d_nopad
    assign d_j = d_root;
  end else begin : g_d_pad
    logic [DW-1:0] dp [PD1];
    always_ff @(posedge clk) begin
      if (en) begin
        dp[0] <= d_root;
        for (int i = 1; i < PD1; i++) begin
          dp[i] <= dp[i-1];
        end
      end
    end
    assign d_j = dp[PD1-1];
  end

  if (PD2 == 0) begin : g_h_nopad
    assign hyp_j = hyp_root;
  end else begin : g_h_pad
    logic [HW-1:0] hp [PD2];
    always_ff @(posedge clk) begin
      if (en) begin
        hp[0] <= hyp_root;
        for (int i = 1; i < PD2; i++) begin
          hp[i] <= hp[i-1];
        end
      end
    end
    assign hyp_j = hp[PD2-1];
  end

  // numerators d*|dy| and d*|dx|; anchor on the reference point gives d / 1 and 0
  logic          hz;
  logic [MW-1:0] pn [2];
  logic [HW-1:0] pden;

  assign hz = (hyp_j == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      pn[0] <= hz ? MW'(d_j) : MW'(d_j) * MW'(ay_d[LAT]);
      pn[1] <= hz ? '0 : MW'(d_j) * MW'(ax_d[LAT]);
      pden  <= hz ? DEN_ONE : hyp_j;
    end
  end

  // overflow check against 2^24, then the remainder seeds the divider
  logic [RMW-1:0] c_rem [2];
  logic           c_sat [2];
  logic [HW-1:0]  c_den;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        c_sat[i] <= CW'(pn[i]) >= (CW'(pden) << 8);
        c_rem[i] <= RMW'({pn[i], {DIR_FRAC{1'b0}}});
      end
      c_den <= pden;
    end
  end

  // per-bit divider, forward and lateral side by side
  logic [RMW-1:0] qd_rem [2][QW];
  logic [QW-1:0]  qd_q   [2][QW];
  logic           qd_sat [2][QW];
  logic [HW-1:0]  qd_den [QW];

  for (genvar t = 0; t < QW; t++) begin : g_qdiv
    logic [RMW-1:0] rem_in [2];
    logic [QW-1:0]  q_in   [2];
    logic           sat_in [2];
    logic [HW-1:0]  den_in;
    logic [RMW-1:0] dsub;
    logic           ge     [2];

    if (t == 0) begin : g_first
      assign rem_in[0] = c_rem[0];
      assign rem_in[1] = c_rem[1];
      assign q_in[0]   = '0;
      assign q_in[1]   = '0;
      assign sat_in[0] = c_sat[0];
      assign sat_in[1] = c_sat[1];
      assign den_in    = c_den;
    end else begin : g_rest
      assign rem_in[0] = qd_rem[0][t-1];
      assign rem_in[1] = qd_rem[1][t-1];
      assign q_in[0]   = qd_q[0][t-1];
      assign q_in[1]   = qd_q[1][t-1];
      assign sat_in[0] = qd_sat[0][t-1];
      assign sat_in[1] = qd_sat[1][t-1];
      assign den_in    = qd_den[t-1];
    end

    assign dsub = RMW'(den_in) << (QW-1-t);

    always_comb begin
      for (int i = 0; i < 2; i++) begin
        ge[i] = rem_in[i] >= dsub;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 2; i++) begin
          qd_rem[i][t] <= ge[i] ? rem_in[i] - dsub : rem_in[i];
          qd_q[i][t]   <= {q_in[i][QW-2:0], ge[i]};
          qd_sat[i][t] <= sat_in[i];
        end
        qd_den[t] <= den_in;
      end
    end
  end

  // output register: sign and saturation
  logic [POS_W-1:0]   forward_pos;
  logic [POS_W-1:0]   lateral_pos;
  logic [COLOR_W-1:0] color_out;

  always_ff @(posedge clk) begin
    if (en) begin
      forward_pos <= sat_signed(qd_q[0][QW-1], qd_sat[0][QW-1], sb[TOT-2].neg_y);
      lateral_pos <= sat_signed(qd_q[1][QW-1], qd_sat[1][QW-1], sb[TOT-2].neg_x);
      color_out   <= sb[TOT-2].color;
    end
  end

  assign m_tdata = {lateral_pos, forward_pos};
  assign m_tuser = color_out;

  // checks
  `CBGP_ASSERT_IMPL(a_div_rem, vld[RW], dv_rem[RW-1] < dv_den[RW-1], "range remainder not below box height")
  `CBGP_ASSERT_NEXT(a_hyp_zero, en && vld[LAT] && hz, pn[1] == '0 && pden == DEN_ONE, "zero offset not mapped to unit divisor")
  `CBGP_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, $stable(vld), "pipeline moved during output stall")

endmodule

// File: rtl/cbgp_sqrt_pipe.sv
// pipelined digit-by-digit integer square root, one root bit per stage
// standalone, no package dependencies
`timescale 1ns / 1ps

module cbgp_sqrt_pipe #(
  parameter int RTW = 17
) (
  input  logic             clk,
  input  logic             en,
  input  logic [2*RTW-1:0] radicand,
  output logic [RTW-1:0]   root
);

  logic [2*RTW-1:0] op_q [RTW];
  logic [RTW-1:0]   rt_q [RTW];
  logic [RTW+1:0]   rm_q [RTW];

  for (genvar j = 0; j < RTW; j++) begin : g_digit
    logic [2*RTW-1:0] op_in;
    logic [RTW-1:0]   rt_in;
    logic [RTW+1:0]   rm_in;
    logic [RTW+1:0]   shifted;
    logic [RTW+1:0]   trial;
    logic             ge;

    if (j == 0) begin : g_first
      assign op_in = radicand;
      assign rt_in = '0;
      assign rm_in = '0;
    end else begin : g_rest
      assign op_in = op_q[j-1];
      assign rt_in = rt_q[j-1];
      assign rm_in = rm_q[j-1];
    end

    // bring down the next pair of radicand bits
    assign shifted = {rm_in[RTW-1:0], op_in[2*(RTW-1-j)+1 -: 2]};
    assign trial   = {rt_in, 2'b01};
    assign ge      = shifted >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rt_q[j] <= {rt_in[RTW-2:0], ge};
      end
    end

    if (j < RTW-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          op_q[j] <= op_in;
          rm_q[j] <= ge ? shifted - trial : shifted;
        end
      end
    end
  end

  assign root = rt_q[RTW-1];

endmodule

// File: verif/tb_top.sv
// self-checking bench for cone_box_to_ground_position: predicts ground position per box
// depends on cbgp_pkg and the cone_box_to_ground_position rtl
`timescale 1ns / 1ps

module tb_top;
  import cbgp_pkg::*;

  localparam int PIXEL_BITS = 12;
  localparam int FRAC_BITS  = 8;
  localparam int IN_W       = ((4*PIXEL_BITS+7)/8)*8;
  localparam int LATENCY    = 72;
  localparam int WATCHDOG   = 20000;

  typedef struct packed {
    logic [COLOR_W-1:0]    color;
    logic [PIXEL_BITS-1:0] height;
    logic [PIXEL_BITS-1:0] width;
    logic [PIXEL_BITS-1:0] top;
    logic [PIXEL_BITS-1:0] left;
  } box_t;

  typedef struct packed {
    logic [POS_W-1:0]   fwd;
    logic [POS_W-1:0]   lat;
    logic [COLOR_W-1:0] color;
  } ground_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [COLOR_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [2*POS_W-1:0] m_tdata;
  logic [COLOR_W-1:0] m_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cone_box_to_ground_position #(.PIXEL_BITS(PIXEL_BITS), .FRAC_BITS(FRAC_BITS)) dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .cfg_we, .cfg_index, .cfg_data
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // predictor's copy of the registers
  longint unsigned img_w, img_h, size_f, big_f, cam_h, big_color;

  box_t    box_q[$];
  ground_t ground_q[$];
  int      errors = 0;
  int      idle_cycles = 0;
  bit      no_gaps = 0;
  bit      hold_send = 0;

  // word accepted at the previous rising edge
  bit s_tready_seen = 0;

  // floor(sqrt(n * 4^k)) bit by bit
  function automatic longint unsigned isqrt_scaled(longint unsigned n, int k);
    longint unsigned root = 0, rem = 0, trial;
    for (int i = 30; i >= 0; i--) begin
      rem = (rem << 2) | ((n >> (2*i)) & 3);
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem -= trial; root = (root << 1) | 1;
      end else root = root << 1;
    end
    for (int j = 0; j < k; j++) begin
      rem = rem << 2;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem -= trial; root = (root << 1) | 1;
      end else root = root << 1;
    end
    return root;
  endfunction

  // magnitude with sign, clamped to 24 bit signed
  function automatic logic [POS_W-1:0] clamp_pos(longint unsigned mag, bit neg);
    longint v;
    if (neg) v = (mag > 64'd8388608) ? -64'sd8388608 : -longint'(mag);
    else v = (mag > 64'd8388607) ? 64'sd8388607 : longint'(mag);
    return v[POS_W-1:0];
  endfunction

  function automatic ground_t predict_ground(box_t b);
    ground_t g;
    longint unsigned f, r, h2, d, adx, ady, hyp, bh;
    longint dx, dy;
    bh = (b.height == 0) ? 1 : b.height;
    f = (b.color == big_color) ? big_f : size_f;
    r = f / bh;
    h2 = cam_h * cam_h;
    d = (r*r > h2) ? isqrt_scaled(r*r - h2, FRAC_BITS) : 0;
    dx = longint'(10*(img_w/2)) - longint'(10*b.left + 5*b.width);
    dy = longint'(15*img_h) - longint'(10*b.top + 7*longint'(b.height));
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    hyp = isqrt_scaled(adx*adx + ady*ady, DIR_FRAC);
    if (hyp == 0) begin
      g.fwd = clamp_pos(d, 0);
      g.lat = '0;
    end else begin
      // floor(num*2^16/hyp) with 128 bit headroom
      g.fwd = clamp_pos(64'((128'(d*ady) << DIR_FRAC) / hyp), dy < 0);
      g.lat = clamp_pos(64'((128'(d*adx) << DIR_FRAC) / hyp), dx < 0);
    end
    g.color = b.color;
    return g;
  endfunction

  // driver: present queued boxes, random gaps
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || s_tready_seen) begin
        if (box_q.size() > 0 && !hold_send && (no_gaps || $urandom_range(99) >= 9)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= IN_W'({box_q[0].height, box_q[0].width, box_q[0].top, box_q[0].left});
          s_tuser  <= box_q[0].color;
          ground_q.insert(ground_q.size(), predict_ground(box_q.pop_front()));
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= no_gaps || ($urandom_range(99) >= 9);
    end
  end

  // monitor: check results, run the watchdog
  always @(posedge clk) begin
    s_tready_seen <= s_tvalid && s_tready;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("Regression FAIL");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        if (ground_q.size() == 0) begin
          $display("%0t: unexpected word fwd=%h lat=%h color=%0d", $realtime,
                   m_tdata[POS_W-1:0], m_tdata[2*POS_W-1:POS_W], m_tuser);
          errors++;
        end else begin
          if (m_tdata[POS_W-1:0] !== ground_q[0].fwd) begin
            $display("%0t: forward_pos expected %h actual %h", $realtime,
                     ground_q[0].fwd, m_tdata[POS_W-1:0]);
            errors++;
          end
          if (m_tdata[2*POS_W-1:POS_W] !== ground_q[0].lat) begin
            $display("%0t: lateral_pos expected %h actual %h", $realtime,
                     ground_q[0].lat, m_tdata[2*POS_W-1:POS_W]);
            errors++;
          end
          if (m_tuser !== ground_q[0].color) begin
            $display("%0t: color_out expected %0d actual %0d", $realtime,
                     ground_q[0].color, m_tuser);
            errors++;
          end
          void'(ground_q.pop_front());
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, longint unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:     img_w = val & 13'h1fff;
      REG_IMAGE_HEIGHT:    img_h = val & 13'h1fff;
      REG_SIZE_FACTOR:     size_f = val & 16'hffff;
      REG_BIG_SIZE_FACTOR: big_f = val & 17'h1ffff;
      REG_CAMERA_HEIGHT:   cam_h = val & 10'h3ff;
      REG_BIG_CONE_COLOR:  big_color = val & 3'h7;
      default: ;
    endcase
  endtask

  // wait for every expected word, then the pipeline depth
  task automatic drain();
    while (box_q.size() > 0 || ground_q.size() > 0 || s_tvalid) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic add_box(box_t b);
    box_q.insert(box_q.size(), b);
  endtask

  function automatic box_t rand_box(int max_h);
    box_t b;
    b.left = $urandom_range(4095);
    b.top = $urandom_range(4095);
    b.width = $urandom_range(4095, 1);
    b.height = $urandom_range(max_h, 1);
    b.color = $urandom_range(7);
    return b;
  endfunction

  task automatic setup(longint unsigned w, longint unsigned h, longint unsigned sf,
                       longint unsigned bf, longint unsigned ch, longint unsigned bc);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_SIZE_FACTOR, sf);
    write_reg(REG_BIG_SIZE_FACTOR, bf);
    write_reg(REG_CAMERA_HEIGHT, ch);
    write_reg(REG_BIG_CONE_COLOR, bc);
  endtask

  task automatic random_phase(int n);
    box_t b;
    for (int i = 0; i < n; i++) begin
      // mostly small boxes so the range stays above camera height
      b = rand_box(($urandom_range(3) == 0) ? 4095 : 200);
      add_box(b);
    end
  endtask

  initial begin
    box_t b;
    img_w = RST_IMAGE_WIDTH; img_h = RST_IMAGE_HEIGHT; size_f = RST_SIZE_FACTOR;
    big_f = RST_BIG_SIZE_FACTOR; cam_h = RST_CAMERA_HEIGHT; big_color = RST_BIG_CONE_COLOR;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed boxes at reset settings: extremes, every color, special cases
    add_box('{color: 0, height: 1, width: 1, top: 0, left: 0});
    add_box('{color: 7, height: 4095, width: 4095, top: 4095, left: 4095});
    add_box('{color: 6, height: 0, width: 10, top: 100, left: 100});   // zero height
    add_box('{color: 1, height: 1000, width: 20, top: 10, left: 10});  // under camera
    // anchor on reference point: 10*320 = 10*left+5*w, 7200 = 10*top+7*h (second box: y only)
    add_box('{color: 2, height: 10, width: 20, top: 713, left: 310});
    add_box('{color: 3, height: 10, width: 4094, top: 713, left: 0});
    for (int c = 0; c < 8; c++)
      add_box('{color: c, height: 12'(c*3+1), width: 50, top: 200, left: 12'(c*90)});
    drain();

    // extreme settings, zero camera height, a box anchored on the reference x
    setup(4096, 4096, 65535, 131071, 0, 5);
    add_box('{color: 5, height: 1, width: 1, top: 0, left: 0});
    add_box('{color: 4, height: 1, width: 4095, top: 4095, left: 4095});
    add_box('{color: 5, height: 2, width: 2, top: 4095, left: 2047});
    random_phase(200);
    drain();

    setup(1, 1, 1, 1, 1023, 3);
    add_box('{color: 3, height: 1, width: 1, top: 0, left: 0});
    random_phase(100);
    drain();

    // long stretch with no idling, then a pause until results drain
    no_gaps = 1;
    setup(640, 480, 30000, 46590, 70, 0);
    random_phase(300);
    while (box_q.size() > 150) @(posedge clk);
    hold_send = 1;
    while (ground_q.size() > 0 || s_tvalid) @(posedge clk);
    hold_send = 0;
    random_phase(100);
    drain();
    no_gaps = 0;

    setup($urandom_range(4096, 1), $urandom_range(4096, 1), $urandom_range(65535, 1),
          $urandom_range(131071, 1), $urandom_range(1023), $urandom_range(5));
    random_phase(400);
    drain();

    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
